// ===== design/dft_iir_pkg.sv =====
// ----------------------------------------------------------------------------
// dft_iir_pkg
// shared widths, register indexes and control types of the direct form II
// iir filter
// ----------------------------------------------------------------------------
package dft_iir_pkg;

	localparam int SAMPLE_W         = 16;  // input / output sample
	localparam int COEF_W           = 24;  // signed q3.20 coefficient
	localparam int DL_W             = 40;  // signed q23.16 delay entry
	localparam int DL_HI_W          = 24;  // upper slice of a delay entry
	localparam int DL_LO_W          = DL_W - DL_HI_W;
	localparam int PH_W             = COEF_W + DL_HI_W;
	localparam int PL_W             = COEF_W + DL_LO_W + 1;
	localparam int PROD_W           = COEF_W + DL_W;
	localparam int PROD_SHIFT       = 12;  // q.36 product down to q.24
	localparam int TERM_W           = PROD_W - PROD_SHIFT;
	localparam int ACC_W            = 56;  // q.24 accumulator
	localparam int X_SHIFT          = 24;  // sample up to q.24
	localparam int W_SHIFT          = 8;   // q.24 down to q.16
	localparam int Y_SHIFT          = 24;  // q.24 down to integer
	localparam int CFG_IDX_W        = 3;
	localparam int MAX_TAPS         = 4;
	localparam int DEFAULT_NUM_TAPS = 4;

	localparam logic signed [COEF_W-1:0] NUM_COEF_0_RST = 24'sh100000;  // 1.0

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_COEF_0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_COEF_1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_COEF_2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_COEF_3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DEN_COEF_1 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_DEN_COEF_2 = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_DEN_COEF_3 = 3'd6;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [COEF_W-1:0]   coef_t;
	typedef logic signed [DL_W-1:0]     dl_t;
	typedef logic signed [ACC_W-1:0]    acc_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_TERM,
		ST_SUM,
		ST_ROUND
	} state_t;

	// strobes to every cell of the row
	typedef struct packed {
		logic shift;    // delay line moves down one place
		logic mul_en;   // register partial products
		logic term_en;  // combine partial products into a q.24 term
		logic sum_en;   // partial sum moves one cell along
		logic fb;       // feedback pass: den coefficients, subtract
	} cell_ctrl_t;

	// strobes to the rounding stage at the end of the row
	typedef struct packed {
		logic w0_load;  // new head of the delay line
		logic y_load;   // new output word
	} round_ctrl_t;

endpackage

// ===== design/dft_iir_cell.sv =====
// ----------------------------------------------------------------------------
// dft_iir_cell
// one tap: delay entry, split multiplier and one step of the sum chain
// ----------------------------------------------------------------------------
module dft_iir_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dft_iir_pkg::cell_ctrl_t ctl,
	input  logic                    w_load,
	input  dft_iir_pkg::dl_t        w_in,
	input  dft_iir_pkg::coef_t      num_coef,
	input  dft_iir_pkg::coef_t      den_coef,
	input  dft_iir_pkg::acc_t       sum_in,
	output dft_iir_pkg::dl_t        w_out,
	output dft_iir_pkg::acc_t       sum_out
);
	import dft_iir_pkg::*;

	dl_t                      w_q;
	logic signed [PH_W-1:0]   ph_q;
	logic signed [PL_W-1:0]   pl_q;
	logic signed [TERM_W-1:0] term_q;
	acc_t                     sum_q;

	coef_t                    coef;
	logic signed [DL_HI_W-1:0] w_hi;
	logic signed [DL_LO_W:0]  w_lo;
	logic signed [PROD_W-1:0] prod;
	acc_t                     term_ext;

	assign coef     = ctl.fb ? den_coef : num_coef;
	assign w_hi     = w_q[DL_W-1:DL_LO_W];
	assign w_lo     = {1'b0, w_q[DL_LO_W-1:0]};
	assign prod     = {ph_q, {DL_LO_W{1'b0}}} + {{(PROD_W-PL_W){pl_q[PL_W-1]}}, pl_q};
	assign term_ext = {{(ACC_W-TERM_W){term_q[TERM_W-1]}}, term_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= '0;
		end else if (w_load) begin
			w_q <= w_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			ph_q <= coef * w_hi;
			pl_q <= coef * w_lo;
		end
		if (ctl.term_en) begin
			term_q <= prod[PROD_W-1:PROD_SHIFT];  // floor shift
		end
		if (ctl.sum_en) begin
			sum_q <= ctl.fb ? sum_in - term_ext : sum_in + term_ext;
		end
	end

	assign w_out   = w_q;
	assign sum_out = sum_q;

endmodule

// ===== design/dft_iir_ctrl.sv =====
// ----------------------------------------------------------------------------
// dft_iir_ctrl
// sequencer: feedback pass, then feedforward pass, over the row of cells
// ----------------------------------------------------------------------------
module dft_iir_ctrl #(
	parameter int NUM_TAPS = dft_iir_pkg::DEFAULT_NUM_TAPS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     slot_free,
	output logic                     in_ready,
	output dft_iir_pkg::cell_ctrl_t  cell_ctl,
	output dft_iir_pkg::round_ctrl_t rnd_ctl
);
	import dft_iir_pkg::*;

	localparam int CNT_W = $clog2(NUM_TAPS);

	state_t           state_q, state_d;
	logic             fb_q;
	logic [CNT_W-1:0] cnt_q;
	logic             last_sum;

	assign last_sum = (cnt_q == CNT_W'(NUM_TAPS - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_MUL;
			ST_MUL:   state_d = ST_TERM;
			ST_TERM:  state_d = ST_SUM;
			ST_SUM:   if (last_sum) state_d = ST_ROUND;
			ST_ROUND: begin
				if (fb_q) begin
					state_d = ST_MUL;
				end else if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready         = 1'b0;
		cell_ctl         = '0;
		rnd_ctl          = '0;
		cell_ctl.fb      = fb_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready       = 1'b1;
				cell_ctl.shift = in_valid;
			end
			ST_MUL:   cell_ctl.mul_en  = 1'b1;
			ST_TERM:  cell_ctl.term_en = 1'b1;
			ST_SUM:   cell_ctl.sum_en  = 1'b1;
			ST_ROUND: begin
				rnd_ctl.w0_load = fb_q;
				rnd_ctl.y_load  = !fb_q && slot_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fb_q    <= 1'b0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && in_valid) begin
				fb_q <= 1'b1;
			end else if (state_q == ST_ROUND) begin
				fb_q <= 1'b0;
			end
			if (state_q == ST_SUM) begin
				cnt_q <= last_sum ? '0 : cnt_q + 1'b1;
			end
		end
	end

endmodule

// ===== design/direct_form_two_iir_filter.sv =====
// ----------------------------------------------------------------------------
// direct_form_two_iir_filter
// third order direct form ii iir filter, row of tap cells with a shared
// multiplier per cell and a registered sum chain
// ----------------------------------------------------------------------------
// sequence: an accepted word runs two passes (feedback, then feedforward)
//   through the row; each pass is multiply, combine, NUM_TAPS sum-chain
//   steps and one round/saturate step; the feedforward round step waits
//   for a free output slot before it loads the output register
// input: a new word is accepted only after the previous one has finished both passes
// reset: delay line cleared to zero, b0 = 1.0, all other coefficients zero
// ----------------------------------------------------------------------------
module direct_form_two_iir_filter #(
	parameter int NUM_TAPS = dft_iir_pkg::DEFAULT_NUM_TAPS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration write port
	input  logic                                  cfg_wr_en,
	input  logic [dft_iir_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dft_iir_pkg::COEF_W-1:0]        cfg_data,
	// input word
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [dft_iir_pkg::SAMPLE_W-1:0] sample_in,
	// output word
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [dft_iir_pkg::SAMPLE_W-1:0] sample_out
);
	import dft_iir_pkg::*;

	localparam int WSH_W = ACC_W - W_SHIFT;  // head before saturation
	localparam int YSH_W = ACC_W - Y_SHIFT;  // output before saturation

	// coefficient registers, den index 0 is a0 and does not exist
	coef_t num_coef_q [0:MAX_TAPS-1];
	coef_t den_coef_q [1:MAX_TAPS-1];

	sample_t     x_q;
	sample_t     y_q;
	logic        out_valid_q;

	cell_ctrl_t  cell_ctl;
	round_ctrl_t rnd_ctl;
	logic        slot_free;

	dl_t  w_chain   [0:NUM_TAPS-1];
	acc_t sum_chain [0:NUM_TAPS-1];
	acc_t sum_seed;
	acc_t acc;

	logic signed [ACC_W-1:0] w_rnd;
	logic signed [WSH_W-1:0] w_shr;
	dl_t                     w0_new;
	logic signed [ACC_W-1:0] y_rnd;
	logic signed [YSH_W-1:0] y_shr;
	sample_t                 y_new;

	// configuration writes, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_coef_q[0] <= NUM_COEF_0_RST;
			num_coef_q[1] <= '0;
			num_coef_q[2] <= '0;
			num_coef_q[3] <= '0;
			den_coef_q[1] <= '0;
			den_coef_q[2] <= '0;
			den_coef_q[3] <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_NUM_COEF_0: num_coef_q[0] <= cfg_data;
				CFG_NUM_COEF_1: num_coef_q[1] <= cfg_data;
				CFG_NUM_COEF_2: num_coef_q[2] <= cfg_data;
				CFG_NUM_COEF_3: num_coef_q[3] <= cfg_data;
				CFG_DEN_COEF_1: den_coef_q[1] <= cfg_data;
				CFG_DEN_COEF_2: den_coef_q[2] <= cfg_data;
				CFG_DEN_COEF_3: den_coef_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// output slot can take a new word when empty or being drained
	assign slot_free = !out_valid_q || out_ready;

	dft_iir_ctrl #(
		.NUM_TAPS (NUM_TAPS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.slot_free (slot_free),
		.in_ready  (in_ready),
		.cell_ctl  (cell_ctl),
		.rnd_ctl   (rnd_ctl)
	);

	// input sample held for the feedback pass
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			x_q <= sample_in;
		end
	end

	// feedback pass starts from x in q.24, feedforward pass from zero
	assign sum_seed = cell_ctl.fb ?
		{{(ACC_W-SAMPLE_W-X_SHIFT){x_q[SAMPLE_W-1]}}, x_q, {X_SHIFT{1'b0}}} : '0;

	// row of tap cells: the head cell loads the rounded w0, the others
	// take their neighbor's entry when a word is accepted
	for (genvar j = 0; j < NUM_TAPS; j++) begin : g_cell
		if (j == 0) begin : g_head
			dft_iir_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (cell_ctl),
				.w_load   (rnd_ctl.w0_load),
				.w_in     (w0_new),
				.num_coef (num_coef_q[0]),
				.den_coef ('0),
				.sum_in   (sum_seed),
				.w_out    (w_chain[0]),
				.sum_out  (sum_chain[0])
			);
		end else begin : g_tail
			dft_iir_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (cell_ctl),
				.w_load   (cell_ctl.shift),
				.w_in     (w_chain[j-1]),
				.num_coef (num_coef_q[j]),
				.den_coef (den_coef_q[j]),
				.sum_in   (sum_chain[j-1]),
				.w_out    (w_chain[j]),
				.sum_out  (sum_chain[j])
			);
		end
	end

	assign acc = sum_chain[NUM_TAPS-1];

	// new head: round half up to q.16, saturate to 40 bits
	assign w_rnd = acc + (ACC_W'(1) << (W_SHIFT - 1));
	assign w_shr = w_rnd[ACC_W-1:W_SHIFT];
	always_comb begin
		if ((&w_shr[WSH_W-1:DL_W-1]) || !(|w_shr[WSH_W-1:DL_W-1])) begin
			w0_new = w_shr[DL_W-1:0];
		end else if (w_shr[WSH_W-1]) begin
			w0_new = {1'b1, {(DL_W-1){1'b0}}};
		end else begin
			w0_new = {1'b0, {(DL_W-1){1'b1}}};
		end
	end

	// output: round half up to integer, saturate to 16 bits
	assign y_rnd = acc + (ACC_W'(1) << (Y_SHIFT - 1));
	assign y_shr = y_rnd[ACC_W-1:Y_SHIFT];
	always_comb begin
		if ((&y_shr[YSH_W-1:SAMPLE_W-1]) || !(|y_shr[YSH_W-1:SAMPLE_W-1])) begin
			y_new = y_shr[SAMPLE_W-1:0];
		end else if (y_shr[YSH_W-1]) begin
			y_new = {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else begin
			y_new = {1'b0, {(SAMPLE_W-1){1'b1}}};
		end
	end

	// output register, the next word may be accepted while it waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rnd_ctl.y_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rnd_ctl.y_load) begin
			y_q <= y_new;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = y_q;

	// one word in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("word accepted while previous one in flight");

	// head load and output load come from different passes
	a_load_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(rnd_ctl.w0_load && rnd_ctl.y_load))
		else $error("head and output loaded together");

	// a pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		rnd_ctl.y_load |-> (!out_valid_q || out_ready))
		else $error("output word overwritten");

	// a loaded result shows up on the port
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		rnd_ctl.y_load |=> out_valid)
		else $error("loaded word not presented");

	// the head is only rewritten inside a word's feedback pass
	a_head_in_pass: assert property (@(posedge clk) disable iff (!arst_n)
		rnd_ctl.w0_load |-> !in_ready && cell_ctl.fb)
		else $error("head loaded outside feedback pass");

endmodule

// ===== tb/iir_filter_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// iir_filter_checker
// watches the configuration port and both word channels of the direct form ii
// filter, keeps its own copy of the coefficients and the delay line, predicts
// every output word and compares it with what the filter hands out
// ----------------------------------------------------------------------------
module iir_filter_checker import dft_iir_pkg::*; #(
	parameter int TAPS = DEFAULT_NUM_TAPS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COEF_W-1:0]    cfg_data,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  sample_t              sample_in,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  sample_t              sample_out,
	output int                   mismatches,
	output int                   pending
);

	localparam int     NUM_COEF_REGS = int'(CFG_DEN_COEF_3) + 1;
	localparam longint HEAD_MAX      = (longint'(1) <<< (DL_W - 1)) - 1;
	localparam longint HEAD_MIN      = -(longint'(1) <<< (DL_W - 1));
	localparam longint OUT_MAX       = 32767;
	localparam int     OUT_MIN       = -32768;

	coef_t   coef_r [NUM_COEF_REGS];
	dl_t     taps_w [MAX_TAPS];
	sample_t expected_words [$];
	int      words_seen;

	task automatic report_mismatch(string msg);
		$display("%0t mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	// exact q.36 product floored to q.24
	function automatic longint product_q24(coef_t c, dl_t w);
		longint p;
		p = longint'(c) * longint'(w);
		return p >>> PROD_SHIFT;
	endfunction

	// shift the delay line, form the new head, then the output word
	function automatic sample_t filter_word(sample_t x);
		longint acc;
		longint head;
		for (int j = TAPS - 1; j > 0; j--)
			taps_w[j] = taps_w[j-1];
		acc = longint'(x) <<< X_SHIFT;
		for (int j = 1; j < TAPS; j++)
			acc -= product_q24(coef_r[int'(CFG_DEN_COEF_1) + j - 1], taps_w[j]);
		head = (acc + (longint'(1) <<< (W_SHIFT - 1))) >>> W_SHIFT;
		if (head > HEAD_MAX)
			head = HEAD_MAX;
		else if (head < HEAD_MIN)
			head = HEAD_MIN;
		taps_w[0] = dl_t'(head);
		acc = 0;
		for (int j = 0; j < TAPS; j++)
			acc += product_q24(coef_r[j], taps_w[j]);
		acc = (acc + (longint'(1) <<< (Y_SHIFT - 1))) >>> Y_SHIFT;
		if (acc > OUT_MAX)
			acc = OUT_MAX;
		else if (acc < OUT_MIN)
			acc = OUT_MIN;
		return sample_t'(acc);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sample_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_COEF_REGS; i++)
				coef_r[i] = '0;
			coef_r[CFG_NUM_COEF_0] = NUM_COEF_0_RST;
			for (int i = 0; i < MAX_TAPS; i++)
				taps_w[i] = '0;
			expected_words.delete();
			words_seen = 0;
			mismatches = 0;
			pending <= 0;
		end else begin
			if (cfg_wr_en && int'(cfg_index) < NUM_COEF_REGS)
				coef_r[cfg_index] = coef_t'(cfg_data);
			if (out_valid && out_ready) begin
				words_seen++;
				if (expected_words.size() == 0) begin
					report_mismatch($sformatf("output word %0d (%0d) with nothing expected",
						words_seen, sample_out));
				end else begin
					want = expected_words.pop_front();
					if (sample_out !== want)
						report_mismatch($sformatf("output word %0d: sample_out %0d, want %0d",
							words_seen, sample_out, want));
				end
			end
			if (in_valid && in_ready)
				expected_words.push_back(filter_word(sample_in));
			pending <= expected_words.size();
		end
	end

endmodule

// ===== tb/direct_form_two_iir_filter_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// direct_form_two_iir_filter_test
// drives the third order iir filter through directed words at the sample and
// coefficient extremes, then through random phases that each load a fresh set
// of coefficients; a checker beside the filter predicts and compares
// ----------------------------------------------------------------------------
module direct_form_two_iir_filter_test import dft_iir_pkg::*;;

	localparam int CLK_PERIOD    = 4;
	localparam int TAPS          = DEFAULT_NUM_TAPS;
	localparam int LATENCY       = 2 * TAPS + 6;
	localparam int NUM_COEF_REGS = int'(CFG_DEN_COEF_3) + 1;
	localparam int NUM_PHASES    = 10;
	localparam int PHASE_WORDS   = 143;
	localparam int HOLD_CYCLES   = 400;
	localparam int LIMIT_NS      = 2_000_000;

	// index past the last coefficient, writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

	localparam coef_t   COEF_MAX   = 24'sh7fffff;
	localparam coef_t   COEF_MIN   = 24'sh800000;
	localparam sample_t SAMPLE_MAX = 16'sh7fff;
	localparam sample_t SAMPLE_MIN = 16'sh8000;

	localparam logic [CFG_IDX_W-1:0] REG_ORDER [NUM_COEF_REGS] = '{
		CFG_NUM_COEF_0, CFG_NUM_COEF_1, CFG_NUM_COEF_2, CFG_NUM_COEF_3,
		CFG_DEN_COEF_1, CFG_DEN_COEF_2, CFG_DEN_COEF_3
	};

	// how a phase picks its coefficients
	typedef enum logic [1:0] {
		MIX_STABLE,   // small feedback, filter stays bounded
		MIX_WILD,     // anything goes, mostly saturating
		MIX_EXTREME   // coefficients at their limits, zero or random
	} mix_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COEF_W-1:0]    cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	sample_t              sample_in;
	logic                 out_valid;
	logic                 out_ready;
	sample_t              sample_out;
	int                   mismatches;
	int                   pending;

	coef_t coef_set [NUM_COEF_REGS];
	bit    quiet;  // sender offers words back to back

	direct_form_two_iir_filter #(
		.NUM_TAPS(TAPS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample_in (sample_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sample_out(sample_out)
	);

	iir_filter_checker #(
		.TAPS(TAPS)
	) checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample_in (sample_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sample_out(sample_out),
		.mismatches(mismatches),
		.pending   (pending)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// hard stop in case a word never shows up
	initial begin
		#(LIMIT_NS);
		$display("== FAIL ==");
		$finish;
	end

	// one register write per clock, enable stays high across a burst
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, coef_t value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
	endtask

	task automatic load_coefs();
		for (int i = 0; i < NUM_COEF_REGS; i++)
			write_reg(REG_ORDER[i], coef_set[i]);
		cfg_wr_en <= 1'b0;
	endtask

	// offer one word after a random gap and hold it until taken
	task automatic send_word(sample_t x);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		sample_in <= x;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// stop offering and wait for every outstanding word, then let the row go idle
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	function automatic coef_t pick_coef(mix_t mix, bit feedback);
		case (mix)
			MIX_STABLE: begin
				// sum of |a| stays at most 0.75, so the loop never runs away
				if (feedback)
					return coef_t'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
				return coef_t'($urandom);
			end
			MIX_EXTREME: begin
				case ($urandom_range(0, 3))
					0: return COEF_MAX;
					1: return COEF_MIN;
					2: return '0;
					default: return coef_t'($urandom);
				endcase
			end
			default: return coef_t'($urandom);
		endcase
	endfunction

	function automatic sample_t pick_sample();
		case ($urandom_range(0, 9))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2: return sample_t'(int'($urandom_range(0, 128)) - 64);
			default: return sample_t'($urandom);
		endcase
	endfunction

	// result side: random stalls per word, some stretches without stalls,
	// and two long hold-offs so the row backs up into the input
	initial begin : result_sink
		int  stall;
		int  taken;
		bit  steady;
		out_ready = 1'b0;
		taken     = 0;
		steady    = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (taken % 64 == 0)
				steady = ($urandom_range(0, 3) == 0);
			stall = steady ? 0 : $urandom_range(0, 15);
			if (taken == 200 || taken == 800)
				stall = HOLD_CYCLES;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			taken++;
		end
	end

	initial begin : stimulus
		mix_t mix;
		arst_n    = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		in_valid  = 1'b0;
		sample_in = '0;
		quiet     = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// a write past the last register must leave the reset identity response
		write_reg(CFG_UNUSED, COEF_MIN);
		cfg_wr_en <= 1'b0;
		send_word('0);
		send_word(SAMPLE_MAX);
		send_word(SAMPLE_MIN);
		send_word(16'sd1);
		send_word(-16'sd1);
		send_word(16'sh5555);
		send_word(16'shaaaa);
		settle();

		// feedback of -8 on every tap: head runs into its rails, output clips high
		for (int i = 0; i < NUM_COEF_REGS; i++)
			coef_set[i] = COEF_MAX;
		coef_set[CFG_DEN_COEF_1] = COEF_MIN;
		coef_set[CFG_DEN_COEF_2] = COEF_MIN;
		coef_set[CFG_DEN_COEF_3] = COEF_MIN;
		load_coefs();
		repeat (6) send_word(SAMPLE_MAX);
		repeat (3) send_word(SAMPLE_MIN);
		settle();

		// opposite corner: largest positive feedback, most negative feedforward
		for (int i = 0; i < NUM_COEF_REGS; i++)
			coef_set[i] = COEF_MIN;
		coef_set[CFG_DEN_COEF_1] = COEF_MAX;
		coef_set[CFG_DEN_COEF_2] = COEF_MAX;
		coef_set[CFG_DEN_COEF_3] = COEF_MAX;
		load_coefs();
		send_word(SAMPLE_MIN);
		send_word(SAMPLE_MAX);
		send_word('0);
		send_word(SAMPLE_MAX);
		send_word(-16'sd1);
		settle();

		// random phases, each with a fresh coefficient set; the sender drains
		// completely at the end of every phase
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p % 5)
				3: mix = MIX_WILD;
				4: mix = MIX_EXTREME;
				default: mix = MIX_STABLE;
			endcase
			quiet = (p != 0) && (p == 1 || $urandom_range(0, 3) == 0);
			for (int i = 0; i < NUM_COEF_REGS; i++)
				coef_set[i] = pick_coef(mix, i >= int'(CFG_DEN_COEF_1));
			load_coefs();
			for (int k = 0; k < PHASE_WORDS; k++)
				send_word(pick_sample());
			settle();
		end

		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
